// ----- rtl/core/dmfs_pkg.sv -----
// ----------------------------------------------------------------------------
// dmfs_pkg: shared types and constants of the dot matrix frame scanner
// Row count, field widths, operation codes and the command bundle that goes
// to the row update logic.
// ----------------------------------------------------------------------------
package dmfs_pkg;

	localparam int ROWS    = 8;
	localparam int ROW_W   = 3;
	localparam int COL_W   = 5;
	localparam int WID_W   = 6;
	localparam int WORD_W  = 32;
	localparam int SEL_W   = 8;

	localparam logic [SEL_W-1:0]  SEL_TOP   = 8'h80;
	localparam logic [WORD_W-1:0] WORD_ONES = 32'hffff_ffff;
	localparam logic [COL_W-1:0]  LAST_COL  = 5'd31;

	typedef enum logic [1:0] {
		OP_SCAN  = 2'd0,
		OP_PIXEL = 2'd1,
		OP_BLIT  = 2'd2
	} op_t;

	// One frame update command as held in the first stage
	typedef struct packed {
		logic [1:0]        operation;
		logic [COL_W-1:0]  column;
		logic              pixel_value;
		logic [WID_W-1:0]  width;
		logic [WORD_W-1:0] row_bits;
	} cmd_t;

endpackage

// ----- rtl/core/dot_matrix_frame_scanner.sv -----
// ----------------------------------------------------------------------------
// dot_matrix_frame_scanner: frame store and row scanner for an LED matrix
// A scan tick gives its result in the cycle after it is taken.
// Throughput: one transaction per cycle; busy stays low, since the frame
// store has one write and two registered read ports with write forwarding.
// Reset clears the row counter and every row word at once by valid bits.
// The receiver cannot stall: each result shows for one cycle on done.
// ----------------------------------------------------------------------------
module dot_matrix_frame_scanner import dmfs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [1:0]        operation,
	input  logic [COL_W-1:0]  column,
	input  logic [ROW_W-1:0]  row,
	input  logic              pixel_value,
	input  logic [WID_W-1:0]  width,
	input  logic [WORD_W-1:0] row_bits,
	output logic              done,
	output logic [SEL_W-1:0]  row_select,
	output logic [WORD_W-1:0] row_word,
	output logic [ROW_W-1:0]  row_index
);

	logic [WORD_W-1:0] mem [ROWS];
	logic [ROWS-1:0]   mem_valid_q;

	logic [ROW_W-1:0]  scan_row_q;
	logic [ROW_W-1:0]  scan_next;
	logic              accept;
	logic              row_ok;

	logic              upd_s1;
	cmd_t              cmd_s1;
	logic [ROW_W-1:0]  row_s1;
	logic [WORD_W-1:0] cur_word_s1;

	logic              upd_wr;
	logic              wr_en;
	logic [WORD_W-1:0] wr_data;

	logic              done_q;
	logic [SEL_W-1:0]  row_select_q;
	logic [WORD_W-1:0] row_word_q;
	logic [ROW_W-1:0]  row_index_q;

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign row_ok = ({1'b0, row} < (ROW_W+1)'(ROWS));

	// Advance the scan row with wrap at the row count
	always_comb begin
		scan_next = scan_row_q + ROW_W'(1);
		if ({1'b0, scan_next} >= (ROW_W+1)'(ROWS)) begin
			scan_next = '0;
		end
	end

	// Compute the updated row word in the first stage
	dmfs_row_update u_update (
		.cmd      (cmd_s1),
		.cur_word (cur_word_s1),
		.wr_en    (upd_wr),
		.new_word (wr_data)
	);

	assign wr_en = upd_s1 && upd_wr;

	// Hold control state: scan counter, stage valid, result strobe, row valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_row_q  <= '0;
			upd_s1      <= 1'b0;
			done_q      <= 1'b0;
			mem_valid_q <= '0;
		end else begin
			upd_s1 <= accept && (operation != OP_SCAN) && row_ok;
			done_q <= accept && (operation == OP_SCAN);
			if (accept && (operation == OP_SCAN)) begin
				scan_row_q <= scan_next;
			end
			if (wr_en) begin
				mem_valid_q[row_s1] <= 1'b1;
			end
		end
	end

	// Write the frame store and register both reads, forwarding the write
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[row_s1] <= wr_data;
		end
		if (accept) begin
			cmd_s1.operation   <= operation;
			cmd_s1.column      <= column;
			cmd_s1.pixel_value <= pixel_value;
			cmd_s1.width       <= width;
			cmd_s1.row_bits    <= row_bits;
			row_s1             <= row;
			if (wr_en && (row_s1 == row)) begin
				cur_word_s1 <= wr_data;
			end else if (row_ok && mem_valid_q[row]) begin
				cur_word_s1 <= mem[row];
			end else begin
				cur_word_s1 <= '0;
			end
			if (wr_en && (row_s1 == scan_next)) begin
				row_word_q <= wr_data;
			end else if (mem_valid_q[scan_next]) begin
				row_word_q <= mem[scan_next];
			end else begin
				row_word_q <= '0;
			end
			row_select_q <= SEL_TOP >> scan_next;
			row_index_q  <= scan_next;
		end
	end

	assign done       = done_q;
	assign row_select = row_select_q;
	assign row_word   = row_word_q;
	assign row_index  = row_index_q;

endmodule

// ----- rtl/core/dmfs_row_update.sv -----
// ----------------------------------------------------------------------------
// dmfs_row_update: new row word for a pixel write or a blit
// Takes the current row word and one command and gives the word to store
// and whether the command writes at all.
// ----------------------------------------------------------------------------
module dmfs_row_update import dmfs_pkg::*; (
	input  cmd_t              cmd,
	input  logic [WORD_W-1:0] cur_word,
	output logic              wr_en,
	output logic [WORD_W-1:0] new_word
);

	logic [COL_W+1:0]  last_sum;
	logic [COL_W-1:0]  last_col;
	logic [WORD_W-1:0] mask;
	logic [WORD_W-1:0] pix_bit;

	// Clamp the blit end column and build the column run mask
	always_comb begin
		last_sum = {2'b00, cmd.column} + {1'b0, cmd.width} - (COL_W+2)'(1);
		if (last_sum > {2'b00, LAST_COL}) begin
			last_col = LAST_COL;
		end else begin
			last_col = last_sum[COL_W-1:0];
		end
		mask = (WORD_ONES >> cmd.column) & (WORD_ONES << (LAST_COL - last_col));
	end

	assign pix_bit = WORD_W'(1) << cmd.column;

	// Merge the command into the row word
	always_comb begin
		wr_en    = 1'b0;
		new_word = cur_word;
		unique case (cmd.operation)
			OP_PIXEL: begin
				wr_en    = 1'b1;
				new_word = cmd.pixel_value ? (cur_word | pix_bit) : (cur_word & ~pix_bit);
			end
			OP_BLIT: begin
				wr_en    = (cmd.width != '0);
				new_word = (cur_word & ~mask) | ((cmd.row_bits >> cmd.column) & mask);
			end
			default: begin
				wr_en    = 1'b0;
				new_word = cur_word;
			end
		endcase
	end

endmodule
